FILE: hdl/smmd_pkg.sv
// Shared types and constants for the microcoded stack-machine datapath.
// Holds request/response payloads, microword layout and ALU/B-bus codes.
// No dependencies.
package smmd_pkg;

  localparam int NREG = 9;

  localparam int R_MAR = 0;
  localparam int R_MDR = 1;
  localparam int R_PC  = 2;
  localparam int R_SP  = 3;
  localparam int R_LV  = 4;
  localparam int R_CPP = 5;
  localparam int R_TOS = 6;
  localparam int R_OPC = 7;
  localparam int R_H   = 8;

  localparam int CS_DEPTH = 512;
  localparam int CS_AW    = 9;
  localparam int UW_W     = 36;

  localparam int MEM_FETCH = 0;
  localparam int MEM_READ  = 1;
  localparam int MEM_WRITE = 2;

  localparam int JAM_Z = 0;
  localparam int JAM_N = 1;
  localparam int JAM_C = 2;

  typedef enum logic [1:0] {
    REQ_LOAD_CW   = 2'd0,
    REQ_LOAD_BYTE = 2'd1,
    REQ_EXEC      = 2'd2
  } smmd_req_e;

  localparam logic [3:0] B_MDR  = 4'd0;
  localparam logic [3:0] B_PC   = 4'd1;
  localparam logic [3:0] B_MBRS = 4'd2;
  localparam logic [3:0] B_MBRU = 4'd3;
  localparam logic [3:0] B_SP   = 4'd4;
  localparam logic [3:0] B_LV   = 4'd5;
  localparam logic [3:0] B_CPP  = 4'd6;
  localparam logic [3:0] B_TOS  = 4'd7;
  localparam logic [3:0] B_OPC  = 4'd8;

  localparam logic [5:0] ALU_AND    = 6'd12;
  localparam logic [5:0] ALU_ONE    = 6'd17;
  localparam logic [5:0] ALU_MONE   = 6'd18;
  localparam logic [5:0] ALU_B      = 6'd20;
  localparam logic [5:0] ALU_H      = 6'd24;
  localparam logic [5:0] ALU_NOTH   = 6'd26;
  localparam logic [5:0] ALU_OR     = 6'd28;
  localparam logic [5:0] ALU_NOTB   = 6'd44;
  localparam logic [5:0] ALU_BINC   = 6'd53;
  localparam logic [5:0] ALU_BDEC   = 6'd54;
  localparam logic [5:0] ALU_HINC   = 6'd57;
  localparam logic [5:0] ALU_NEGH   = 6'd59;
  localparam logic [5:0] ALU_ADD    = 6'd60;
  localparam logic [5:0] ALU_ADDINC = 6'd61;
  localparam logic [5:0] ALU_SUB    = 6'd63;

  localparam logic [1:0] SH_SRA1 = 2'd1;
  localparam logic [1:0] SH_SLL8 = 2'd2;

  typedef struct packed {
    logic [8:0] next_addr;
    logic [2:0] jam;
    logic [1:0] shift;
    logic [5:0] alu;
    logic [8:0] wmask;
    logic [2:0] mem;
    logic [3:0] bsel;
  } smmd_uword_t;

  typedef logic [NREG-1:0][31:0] smmd_regs_t;

  typedef struct packed {
    logic [31:0] c;
    logic        z;
  } smmd_alu_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] load_address;
    logic [35:0] load_data;
  } smmd_req_t;

  typedef struct packed {
    logic [8:0]  next_micro_address;
    logic [31:0] program_counter;
    logic [31:0] stack_pointer;
    logic [31:0] top_of_stack;
    logic [7:0]  fetched_byte;
    logic [31:0] c_bus_value;
    logic        zero_flag;
  } smmd_rsp_t;

endpackage

FILE: hdl/smmd_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module smmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/smmd_alu.sv
// B-bus select, ALU and shifter of one microinstruction.
// Depends on smmd_pkg.
module smmd_alu
  import smmd_pkg::*;
(
  input  smmd_uword_t uw_i,
  input  smmd_regs_t  regs_i,
  input  logic [7:0]  mbr_i,
  input  logic [31:0] prev_i,
  output smmd_alu_t   res_o
);

  logic [31:0] b_bus;
  logic [31:0] h;
  logic [31:0] alu_out;

  assign h = regs_i[R_H];

  always_comb begin
    case (uw_i.bsel)
      B_MDR:   b_bus = regs_i[R_MDR];
      B_PC:    b_bus = regs_i[R_PC];
      B_MBRS:  b_bus = {{24{mbr_i[7]}}, mbr_i};
      B_MBRU:  b_bus = {24'd0, mbr_i};
      B_SP:    b_bus = regs_i[R_SP];
      B_LV:    b_bus = regs_i[R_LV];
      B_CPP:   b_bus = regs_i[R_CPP];
      B_TOS:   b_bus = regs_i[R_TOS];
      B_OPC:   b_bus = regs_i[R_OPC];
      default: b_bus = '1;
    endcase
  end

  always_comb begin
    case (uw_i.alu)
      ALU_AND:    alu_out = h & b_bus;
      ALU_ONE:    alu_out = 32'd1;
      ALU_MONE:   alu_out = '1;
      ALU_B:      alu_out = b_bus;
      ALU_H:      alu_out = h;
      ALU_NOTH:   alu_out = ~h;
      ALU_OR:     alu_out = h | b_bus;
      ALU_NOTB:   alu_out = ~b_bus;
      ALU_BINC:   alu_out = b_bus + 32'd1;
      ALU_BDEC:   alu_out = b_bus - 32'd1;
      ALU_HINC:   alu_out = h + 32'd1;
      ALU_NEGH:   alu_out = 32'd0 - h;
      ALU_ADD:    alu_out = h + b_bus;
      ALU_ADDINC: alu_out = h + b_bus + 32'd1;
      ALU_SUB:    alu_out = b_bus - h;
      default:    alu_out = prev_i;
    endcase
  end

  always_comb begin
    res_o.z = (alu_out == 32'd0);
    case (uw_i.shift)
      SH_SRA1: res_o.c = {alu_out[31], alu_out[31:1]};
      SH_SLL8: res_o.c = {alu_out[23:0], 8'd0};
      default: res_o.c = alu_out;
    endcase
  end

endmodule

FILE: hdl/smmd_mod.sv
// Reduction of a 32-bit byte address modulo the memory size.
// Reciprocal multiply for the quotient, then subtract and one correction step.
// Depends on smmd_pkg.
module smmd_mod
  import smmd_pkg::*;
#(
  parameter int MEM_BYTES = 65536
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [31:0]                  value_i,
  output logic                         done_o,
  output logic [$clog2(MEM_BYTES)-1:0] rem_o
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [31:0] MOD_C   = 32'(MEM_BYTES);
  localparam logic [31:0] RECIP_C = 32'(64'h1_0000_0000 / 64'(MEM_BYTES));

  typedef enum logic [1:0] {
    PH_IDLE, PH_QUOT, PH_SUB, PH_FIX
  } phase_e;

  phase_e      phase_q;
  logic        done_q;
  logic [31:0] x_q;
  logic [31:0] q_q;
  logic [63:0] prod;
  logic [31:0] qm;

  assign prod = {32'd0, x_q} * {32'd0, RECIP_C};
  assign qm   = q_q * MOD_C;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
      x_q     <= '0;
      q_q     <= '0;
    end else begin
      done_q <= (phase_q == PH_FIX) && !start_i;
      if (start_i) begin
        x_q     <= value_i;
        phase_q <= PH_QUOT;
      end else begin
        case (phase_q)
          PH_QUOT: begin
            q_q     <= prod[63:32];
            phase_q <= PH_SUB;
          end
          PH_SUB: begin
            x_q     <= x_q - qm;
            phase_q <= PH_FIX;
          end
          PH_FIX: begin
            if (x_q >= MOD_C) begin
              x_q <= x_q - MOD_C;
            end
            phase_q <= PH_IDLE;
          end
          default: phase_q <= PH_IDLE;
        endcase
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = x_q[AW-1:0];

endmodule

FILE: hdl/stack_machine_microcoded_datapath.sv
// Microcoded stack-machine datapath: control store and byte memory in synchronous RAMs.
// Each byte access passes through the address reduction (quotient, subtract, correction)
//   and then the single byte-wide memory port; a load byte does one write, and an execute
//   does a fetch, four read bytes and four write bytes as its microword asks.
// The sequencer holds one item at a time; a one-entry input register takes the next item,
//   and a full result register stalls the sequencer until it is taken. Reset: registers,
//   flags, micro PC and C-bus hold clear; both memories hold no reset value.
module stack_machine_microcoded_datapath
  import smmd_pkg::*;
#(
  parameter int MEM_BYTES = 65536
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  smmd_req_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output smmd_rsp_t out_data_o
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [1:0] LANE_LAST = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_ADR, S_MOD, S_MEM, S_CAP, S_JAM, S_OUT
  } state_e;

  typedef enum logic [2:0] {
    ACC_NONE, ACC_STORE, ACC_FETCH, ACC_RD, ACC_WR
  } acc_e;

  typedef struct packed {
    state_e     st;
    acc_e       acc;
    logic [1:0] lane;
  } seq_t;

  function automatic seq_t next_access(input acc_e f, input logic [1:0] ln,
                                       input logic [2:0] m);
    seq_t s;
    s.st   = S_JAM;
    s.acc  = ACC_NONE;
    s.lane = 2'd0;
    case (f)
      ACC_NONE: begin
        if (m[MEM_FETCH]) begin
          s.st  = S_ADR;
          s.acc = ACC_FETCH;
        end else if (m[MEM_READ]) begin
          s.st  = S_ADR;
          s.acc = ACC_RD;
        end else if (m[MEM_WRITE]) begin
          s.st  = S_ADR;
          s.acc = ACC_WR;
        end
      end
      ACC_FETCH: begin
        if (m[MEM_READ]) begin
          s.st  = S_ADR;
          s.acc = ACC_RD;
        end else if (m[MEM_WRITE]) begin
          s.st  = S_ADR;
          s.acc = ACC_WR;
        end
      end
      ACC_RD: begin
        if (ln != LANE_LAST) begin
          s.st   = S_ADR;
          s.acc  = ACC_RD;
          s.lane = ln + 2'd1;
        end else if (m[MEM_WRITE]) begin
          s.st  = S_ADR;
          s.acc = ACC_WR;
        end
      end
      ACC_WR: begin
        if (ln != LANE_LAST) begin
          s.st   = S_ADR;
          s.acc  = ACC_WR;
          s.lane = ln + 2'd1;
        end
      end
      ACC_STORE: s.st = S_OUT;
      default:   s.st = S_JAM;
    endcase
    return s;
  endfunction

  function automatic logic [8:0] jam_addr(input smmd_uword_t uw, input logic z,
                                          input logic n, input logic [7:0] mbr);
    logic [8:0] a;
    a = uw.next_addr;
    if (uw.jam[JAM_Z]) begin
      a = a | {z, 8'd0};
    end
    if (uw.jam[JAM_N]) begin
      a = a | {n, 8'd0};
    end
    if (uw.jam[JAM_C]) begin
      a = a | {1'b0, mbr};
    end
    return a;
  endfunction

  state_e      state_q, state_d;
  smmd_req_t   buf_q, buf_d;
  logic        buf_vld_q, buf_vld_d;
  smmd_req_t   cur_q, cur_d;
  smmd_uword_t uw_q, uw_d;
  logic [8:0]  upc_q, upc_d;
  smmd_regs_t  regs_q, regs_d;
  logic [7:0]  mbr_q, mbr_d;
  logic [31:0] chold_q, chold_d;
  logic        z_q, z_d;
  logic        n_q, n_d;
  acc_e        acc_q, acc_d;
  logic [1:0]  lane_q, lane_d;
  smmd_rsp_t   out_q, out_d;
  logic        out_vld_q, out_vld_d;

  logic              cs_we;
  logic [CS_AW-1:0]  cs_addr;
  logic [UW_W-1:0]   cs_rdata;
  smmd_uword_t       cs_word;
  logic              mem_we;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;
  logic              mod_start;
  logic [31:0]       mod_val;
  logic              mod_done;
  logic [AW-1:0]     mod_rem;
  logic              out_load;
  smmd_alu_t         alu_res;
  seq_t              seq;

  assign cs_word    = smmd_uword_t'(cs_rdata);
  assign cs_addr    = (buf_q.req_type == REQ_LOAD_CW) ? buf_q.load_address[CS_AW-1:0] : upc_q;
  assign in_ready_o = !buf_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  smmd_ram #(
    .WIDTH (UW_W),
    .DEPTH (CS_DEPTH)
  ) u_cs (
    .clk_i   (clk_i),
    .we_i    (cs_we),
    .addr_i  (cs_addr),
    .wdata_i (buf_q.load_data),
    .rdata_o (cs_rdata)
  );

  smmd_ram #(
    .WIDTH (8),
    .DEPTH (MEM_BYTES)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mod_rem),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  smmd_mod #(
    .MEM_BYTES (MEM_BYTES)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .value_i (mod_val),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  smmd_alu u_alu (
    .uw_i   (cs_word),
    .regs_i (regs_q),
    .mbr_i  (mbr_q),
    .prev_i (chold_q),
    .res_o  (alu_res)
  );

  always_comb begin
    case (acc_q)
      ACC_STORE: mod_val = 32'(cur_q.load_address);
      ACC_FETCH: mod_val = regs_q[R_PC];
      default:   mod_val = {regs_q[R_MAR][29:0], 2'b00} + 32'(lane_q);
    endcase
    if (acc_q == ACC_STORE) begin
      mem_wdata = cur_q.load_data[7:0];
    end else begin
      mem_wdata = regs_q[R_MDR][{lane_q, 3'b000} +: 8];
    end
  end

  always_comb begin
    state_d   = state_q;
    buf_d     = buf_q;
    buf_vld_d = buf_vld_q;
    cur_d     = cur_q;
    uw_d      = uw_q;
    upc_d     = upc_q;
    regs_d    = regs_q;
    mbr_d     = mbr_q;
    chold_d   = chold_q;
    z_d       = z_q;
    n_d       = n_q;
    acc_d     = acc_q;
    lane_d    = lane_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    cs_we     = 1'b0;
    mod_start = 1'b0;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    seq       = '{st: S_JAM, acc: ACC_NONE, lane: 2'd0};

    if (in_valid_i && in_ready_o) begin
      buf_d     = in_data_i;
      buf_vld_d = 1'b1;
    end
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (buf_vld_q) begin
          buf_vld_d = 1'b0;
          cur_d     = buf_q;
          case (buf_q.req_type)
            REQ_LOAD_CW: begin
              cs_we   = 1'b1;
              state_d = S_OUT;
            end
            REQ_LOAD_BYTE: begin
              acc_d   = ACC_STORE;
              lane_d  = 2'd0;
              state_d = S_ADR;
            end
            REQ_EXEC: state_d = S_DEC;
            default:  state_d = S_OUT;
          endcase
        end
      end
      S_DEC: begin
        uw_d    = cs_word;
        chold_d = alu_res.c;
        z_d     = alu_res.z;
        n_d     = !alu_res.z;
        for (int i = 0; i < NREG; i++) begin
          if (cs_word.wmask[i]) begin
            regs_d[i] = alu_res.c;
          end
        end
        seq     = next_access(ACC_NONE, 2'd0, cs_word.mem);
        state_d = seq.st;
        acc_d   = seq.acc;
        lane_d  = seq.lane;
        if (seq.st == S_JAM) begin
          upc_d   = jam_addr(cs_word, alu_res.z, !alu_res.z, mbr_q);
          state_d = S_OUT;
        end
      end
      S_ADR: begin
        mod_start = 1'b1;
        state_d   = S_MOD;
      end
      S_MOD: begin
        if (mod_done) begin
          state_d = S_MEM;
        end
      end
      S_MEM: begin
        case (acc_q)
          ACC_STORE, ACC_WR: begin
            mem_we  = 1'b1;
            seq     = next_access(acc_q, lane_q, uw_q.mem);
            state_d = seq.st;
            acc_d   = seq.acc;
            lane_d  = seq.lane;
          end
          ACC_FETCH, ACC_RD: state_d = S_CAP;
          default:           state_d = S_JAM;
        endcase
      end
      S_CAP: begin
        if (acc_q == ACC_FETCH) begin
          mbr_d = mem_rdata;
        end else begin
          regs_d[R_MDR][{lane_q, 3'b000} +: 8] = mem_rdata;
        end
        seq     = next_access(acc_q, lane_q, uw_q.mem);
        state_d = seq.st;
        acc_d   = seq.acc;
        lane_d  = seq.lane;
      end
      S_JAM: begin
        upc_d   = jam_addr(uw_q, z_q, n_q, mbr_q);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_vld_q || out_ready_i) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          out_d     = '{next_micro_address: upc_q,
                        program_counter:    regs_q[R_PC],
                        stack_pointer:      regs_q[R_SP],
                        top_of_stack:       regs_q[R_TOS],
                        fetched_byte:       mbr_q,
                        c_bus_value:        chold_q,
                        zero_flag:          z_q};
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      buf_q     <= '0;
      buf_vld_q <= 1'b0;
      cur_q     <= '0;
      uw_q      <= '0;
      upc_q     <= '0;
      regs_q    <= '0;
      mbr_q     <= '0;
      chold_q   <= '0;
      z_q       <= 1'b0;
      n_q       <= 1'b0;
      acc_q     <= ACC_NONE;
      lane_q    <= '0;
      out_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      buf_q     <= buf_d;
      buf_vld_q <= buf_vld_d;
      cur_q     <= cur_d;
      uw_q      <= uw_d;
      upc_q     <= upc_d;
      regs_q    <= regs_d;
      mbr_q     <= mbr_d;
      chold_q   <= chold_d;
      z_q       <= z_d;
      n_q       <= n_d;
      acc_q     <= acc_d;
      lane_q    <= lane_d;
      out_q     <= out_d;
      out_vld_q <= out_vld_d;
    end
  end

`ifndef SYNTH
  a_dec_after_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEC) |-> ($past(state_q) == S_IDLE))
    else $error("decode not preceded by control store read");

  a_mod_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == S_MOD))
    else $error("address reduction finished outside wait state");

  a_mem_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we || state_q == S_CAP) |-> (32'(mod_rem) < 32'(MEM_BYTES)))
    else $error("memory index beyond memory size");

  a_out_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_vld_q || out_ready_i))
    else $error("result register overwritten before transfer");
`endif

endmodule
